// ----- hw/rtl/ftc_pkg.sv -----
package ftc_pkg;
  localparam int unsigned FrameBitsDef = 32;
  localparam int unsigned RateW = 7;
  localparam int unsigned DropsW = 4;
  localparam int unsigned AddrW = 4;
  localparam logic [AddrW-1:0] AddrRate  = 4'h0;
  localparam logic [AddrW-1:0] AddrDrop  = 4'h4;
  localparam logic [AddrW-1:0] AddrDrops = 4'h8;

  typedef struct packed {
    logic [RateW-1:0]  rate;
    logic              drop_en;
    logic [DropsW-1:0] drops;
  } cfg_t;
endpackage

// ----- hw/rtl/ftc_div.sv -----
module ftc_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 14,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [DenW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);
  // one quotient bit per stage, restoring
  logic               v_q [NumW];
  logic [NumW-1:0]    n_q [NumW];
  logic [NumW-1:0]    q_q [NumW];
  logic [DenW-1:0]    r_q [NumW];
  logic [DenW-1:0]    d_q [NumW];
  logic [SideW-1:0]   s_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_st
    logic             v_in;
    logic [NumW-1:0]  n_in, q_in;
    logic [DenW-1:0]  r_in, d_in;
    logic [SideW-1:0] s_in;
    logic [DenW:0]    sh, df;

    if (k == 0) begin : g_head
      assign v_in = valid_i;
      assign n_in = num_i;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_body
      assign v_in = v_q[k-1];
      assign n_in = n_q[k-1];
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign s_in = s_q[k-1];
    end

    always_comb begin
      sh = {r_in, n_in[NumW-1-k]};
      df = sh - {1'b0, d_in};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_in;
        d_q[k] <= d_in;
        s_q[k] <= s_in;
        if (sh >= {1'b0, d_in}) begin
          r_q[k] <= df[DenW-1:0];
          q_q[k] <= q_in | (NumW'(1) << (NumW-1-k));
        end else begin
          r_q[k] <= sh[DenW-1:0];
          q_q[k] <= q_in;
        end
      end
    end
  end

  assign valid_o = v_q[NumW-1];
  assign quo_o   = q_q[NumW-1];
  assign rem_o   = r_q[NumW-1];
  assign side_o  = s_q[NumW-1];
endmodule

// ----- hw/rtl/ftc_regs.sv -----
module ftc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ftc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ftc_pkg::cfg_t              cfg_o
);
  import ftc_pkg::*;
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rate: RateW'(30), drop_en: 1'b0, drops: DropsW'(2)};
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrRate:  cfg_q.rate    <= pwdata[RateW-1:0];
        AddrDrop:  cfg_q.drop_en <= pwdata[0];
        AddrDrops: cfg_q.drops   <= pwdata[DropsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrRate:  prdata = {25'd0, cfg_q.rate};
      AddrDrop:  prdata = {31'd0, cfg_q.drop_en};
      AddrDrops: prdata = {28'd0, cfg_q.drops};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;
endmodule

// ----- hw/rtl/frame_number_to_timecode.sv -----
// Fully pipelined frame count to HH:MM:SS:FF converter. One transaction per
// clock when not stalled. The pipeline is built from two FRAME_BITS-stage
// one-bit-per-stage dividers (ten-minute block, frames per second), a
// 17-stage minute-within-block divider, two glue stages and four
// reciprocal stages for seconds, minutes and hours. A stall freezes the whole
// pipeline. Registers: rate at 0x0, drop-frame enable at 0x4, drops per
// minute at 0x8.
module frame_number_to_timecode #(
  parameter int unsigned FRAME_BITS = ftc_pkg::FrameBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ftc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [31:0]               frame_number_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [4:0]                hours_o,
  output logic [5:0]                minutes_o,
  output logic [5:0]                seconds_o,
  output logic [6:0]                frames_o,
  output logic                      drop_flag_o
);
  import ftc_pkg::*;
  localparam int unsigned FB = FRAME_BITS;
  localparam int unsigned PmW = 14;
  localparam int unsigned PtW = 17;

  cfg_t cfg;
  ftc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  logic en;
  assign en = !(valid_o && stall_i);
  assign stall_o = !en;

  logic [RateW-1:0] rate;
  logic [PmW-1:0]   per_min;
  logic [PtW-1:0]   per_ten;
  assign rate    = (cfg.rate == '0) ? RateW'(1) : cfg.rate;
  assign per_min = PmW'(rate) * PmW'(60) - PmW'(cfg.drops);
  assign per_ten = PtW'(per_min) * PtW'(10) + PtW'(cfg.drops);

  // stage A: blocks and rem
  logic          va;
  logic [FB-1:0] blocks, na;
  logic [PtW-1:0] rem;
  ftc_div #(.NumW(FB), .DenW(PtW), .SideW(FB)) u_div_ten (
    .clk_i, .rst_ni, .en_i(en), .valid_i,
    .num_i(frame_number_i[FB-1:0]), .den_i(per_ten), .side_i(frame_number_i[FB-1:0]),
    .valid_o(va), .quo_o(blocks), .rem_o(rem), .side_o(na)
  );

  logic          vb_q;
  logic [FB-1:0] nb_q, add_b_q;
  logic [PtW-1:0] remd_q;
  logic          big_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nb_q    <= na;
      add_b_q <= FB'(blocks * (FB'(cfg.drops) * FB'(9)));
      big_q   <= rem > PtW'(cfg.drops);
      remd_q  <= rem - PtW'(cfg.drops);
    end
  end

  logic          vm;
  logic [PtW-1:0] mins;
  logic [2*FB-1:0] sm;
  ftc_div #(.NumW(PtW), .DenW(PmW), .SideW(2*FB)) u_div_min (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q),
    .num_i(big_q ? remd_q : '0), .den_i(per_min), .side_i({nb_q, add_b_q}),
    .valid_o(vm), .quo_o(mins), .rem_o(), .side_o(sm)
  );

  logic          vp_q;
  logic [FB-1:0] proj_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (en) vp_q <= vm;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      proj_q <= cfg.drop_en ?
        sm[2*FB-1:FB] + sm[FB-1:0] + FB'(mins[7:0] * cfg.drops) : sm[2*FB-1:FB];
    end
  end

  logic          vs;
  logic [FB-1:0] tsec;
  logic [RateW-1:0] fr;
  ftc_div #(.NumW(FB), .DenW(RateW), .SideW(1)) u_div_sec (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vp_q),
    .num_i(proj_q), .den_i(rate), .side_i(1'b0),
    .valid_o(vs), .quo_o(tsec), .rem_o(fr), .side_o()
  );

  // seconds/minutes/hours by reciprocal multiply, remainders by multiply-back
  logic [3:0]    vt_q;
  logic [FB-1:0] tsec1_q, tmin1_q, tmin2_q, hrs2_q, hrs3_q, q24_q;
  logic [5:0]    sec2_q, sec3_q, min3_q;
  logic [6:0]    fr1_q, fr2_q, fr3_q;
  logic [FB-1:0] hrs_div8;
  assign hrs_div8 = hrs2_q >> 3;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= '0;
    end else if (en) begin
      vt_q <= {vt_q[2:0], vs};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tsec1_q   <= tsec;
      tmin1_q   <= FB'((64'(tsec) * 64'h8888_8889) >> 37);
      fr1_q     <= fr;
      sec2_q    <= 6'(tsec1_q - FB'(tmin1_q * FB'(60)));
      tmin2_q   <= tmin1_q;
      hrs2_q    <= FB'((64'(tmin1_q) * 64'h8888_8889) >> 37);
      fr2_q     <= fr1_q;
      min3_q    <= 6'(tmin2_q - FB'(hrs2_q * FB'(60)));
      hrs3_q    <= hrs2_q;
      q24_q     <= FB'((64'(hrs_div8) * 64'hAAAA_AAAB) >> 33);
      sec3_q    <= sec2_q;
      fr3_q     <= fr2_q;
      hours_o   <= 5'(hrs3_q - FB'(q24_q * FB'(24)));
      minutes_o <= min3_q;
      seconds_o <= sec3_q;
      frames_o  <= fr3_q;
    end
  end
  assign valid_o     = vt_q[3];
  assign drop_flag_o = cfg.drop_en;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(frames_o))
    else $error("output changed under stall");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> minutes_o < 6'd60 && seconds_o < 6'd60 && hours_o < 5'd24)
    else $error("field out of range");
  a_fr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> frames_o < rate)
    else $error("frames not below rate");
`endif
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ftc_pkg::*;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] frames;
    logic       drop_flag;
  } timecode_t;

  localparam int unsigned DrainCycles = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [31:0] frame_number_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [4:0] hours_o;
  logic [5:0] minutes_o, seconds_o;
  logic [6:0] frames_o;
  logic drop_flag_o;

  cfg_t cfg;
  timecode_t timecode_q[$];
  int unsigned errors = 0;
  bit hold_off = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned burst_left = 0;

  frame_number_to_timecode dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic timecode_t to_timecode(logic [31:0] n);
    logic [31:0] rate, d, per_min, per_ten, blocks, rem, addend, proj, tsec, tmin;
    timecode_t tc;
    rate = (cfg.rate == 0) ? 32'd1 : 32'(cfg.rate);
    proj = n;
    if (cfg.drop_en) begin
      d = 32'(cfg.drops);
      per_min = rate * 60 - d;
      per_ten = per_min * 10 + d;
      blocks = n / per_ten;
      rem = n % per_ten;
      addend = d * 9 * blocks;
      if (rem > d) addend = addend + d * ((rem - d) / per_min);
      proj = n + addend;
    end
    tsec = proj / rate;
    tmin = tsec / 60;
    tc.hours = 5'((tmin / 60) % 24);
    tc.minutes = 6'(tmin % 60);
    tc.seconds = 6'(tsec % 60);
    tc.frames = 7'(proj % rate);
    tc.drop_flag = cfg.drop_en;
    return tc;
  endfunction

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) begin
      stall_i <= 1'b1;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) begin
        hold_off <= 1'b0;
        hold_cycles <= 0;
      end
    end else if ($time < 2000) begin
      stall_i <= 1'b0;
    end else begin
      stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    timecode_t exp_tc;
    if (rst_ni && valid_o && !stall_i) begin
      if (timecode_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time,
                 {hours_o, minutes_o, seconds_o, frames_o, drop_flag_o});
        errors++;
      end else begin
        exp_tc = timecode_q.pop_front();
        if (hours_o !== exp_tc.hours) begin
          $display("%0t: hours exp %0d got %0d", $time, exp_tc.hours, hours_o);
          errors++;
        end
        if (minutes_o !== exp_tc.minutes) begin
          $display("%0t: minutes exp %0d got %0d", $time, exp_tc.minutes, minutes_o);
          errors++;
        end
        if (seconds_o !== exp_tc.seconds) begin
          $display("%0t: seconds exp %0d got %0d", $time, exp_tc.seconds, seconds_o);
          errors++;
        end
        if (frames_o !== exp_tc.frames) begin
          $display("%0t: frames exp %0d got %0d", $time, exp_tc.frames, frames_o);
          errors++;
        end
        if (drop_flag_o !== exp_tc.drop_flag) begin
          $display("%0t: drop_flag exp %0d got %0d", $time, exp_tc.drop_flag,
                   drop_flag_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      AddrRate:  cfg.rate = data[RateW-1:0];
      AddrDrop:  cfg.drop_en = data[0];
      AddrDrops: cfg.drops = data[DropsW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(logic [31:0] n, bit gaps);
    int unsigned gap;
    if (gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    valid_i <= 1'b1;
    frame_number_i <= n;
    do @(posedge clk_i); while (stall_o);
    timecode_q.push_back(to_timecode(n));
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (timecode_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [6:0] rate, logic drop_en, logic [3:0] drops);
    wait_drained();
    write_reg(AddrRate, 32'(rate));
    write_reg(AddrDrop, 32'(drop_en));
    write_reg(AddrDrops, 32'(drops));
  endtask

  task automatic test_directed();
    logic [31:0] vals [16] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd17981, 32'd17982,
                               32'd1799, 32'd1800, 32'd1801, 32'd2589407, 32'd2589408,
                               32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                               32'h5555_5555, 32'hAAAA_AAAA};
    foreach (vals[i]) send_frame(vals[i], 1'b0);
    set_cfg(7'd30, 1'b1, 4'd2);
    foreach (vals[i]) send_frame(vals[i], 1'b0);
    set_cfg(7'd0, 1'b1, 4'd15);
    foreach (vals[i]) send_frame(vals[i], 1'b0);
    set_cfg(7'd127, 1'b1, 4'd15);
    foreach (vals[i]) send_frame(vals[i], 1'b0);
    set_cfg(7'd1, 1'b0, 4'd0);
    foreach (vals[i]) send_frame(vals[i], 1'b0);
  endtask

  function automatic logic [31:0] rand_frame();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20000);
      1: return $urandom_range(0, 3000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(int unsigned count);
    repeat (count) send_frame(rand_frame(), 1'b1);
  endtask

  task automatic test_configs();
    set_cfg(7'd60, 1'b1, 4'd4);
    test_random(150);
    set_cfg(7'd120, 1'b1, 4'd8);
    test_random(150);
    set_cfg(7'd25, 1'b0, 4'd0);
    test_random(150);
    set_cfg(7'($urandom_range(0, 127)), 1'($urandom), 4'($urandom));
    test_random(150);
  endtask

  task automatic test_backpressure();
    set_cfg(7'd30, 1'b1, 4'd2);
    hold_off = 1'b1;
    repeat (250) send_frame(rand_frame(), 1'b0);
    wait_drained();
    test_random(50);
  endtask

  initial begin
    cfg = '{rate: 7'd30, drop_en: 1'b0, drops: 4'd2};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_configs();
    test_backpressure();
    wait_drained();
    if (errors == 0 && timecode_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
